>>> sv/npcs_pkg.sv
`timescale 1ns / 1ps

package npcs_pkg;

  // Palette geometry
  localparam int PALETTE_DEPTH    = 256;
  localparam int SEARCHED_ENTRIES = 255;
  localparam int SCAN_LIMIT       = (SEARCHED_ENTRIES < PALETTE_DEPTH) ?
                                    SEARCHED_ENTRIES : PALETTE_DEPTH;
  localparam int IDX_W            = $clog2(PALETTE_DEPTH);

  // Color and distance widths
  localparam int CH_W    = 8;
  localparam int RGB_W   = 3 * CH_W;
  localparam int DIST_W  = 10;
  localparam int BEST_W  = 11;
  localparam logic [BEST_W-1:0] DIST_START = BEST_W'(1024);

  // Opcodes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Sequencer states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  typedef logic [RGB_W-1:0] rgb_t;

endpackage

>>> sv/npcs_ram.sv
`timescale 1ns / 1ps

module npcs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

>>> sv/npcs_dist.sv
`timescale 1ns / 1ps

module npcs_dist import npcs_pkg::*; (
  input  rgb_t              entry,
  input  rgb_t              query,
  output logic [DIST_W-1:0] sad
);

  logic [CH_W-1:0] dr;
  logic [CH_W-1:0] dg;
  logic [CH_W-1:0] db;

  // Take absolute channel differences
  always_comb begin
    dr = (entry[2*CH_W +: CH_W] > query[2*CH_W +: CH_W]) ?
         entry[2*CH_W +: CH_W] - query[2*CH_W +: CH_W] :
         query[2*CH_W +: CH_W] - entry[2*CH_W +: CH_W];
    dg = (entry[CH_W +: CH_W] > query[CH_W +: CH_W]) ?
         entry[CH_W +: CH_W] - query[CH_W +: CH_W] :
         query[CH_W +: CH_W] - entry[CH_W +: CH_W];
    db = (entry[0 +: CH_W] > query[0 +: CH_W]) ?
         entry[0 +: CH_W] - query[0 +: CH_W] :
         query[0 +: CH_W] - entry[0 +: CH_W];
  end

  // Sum the three differences
  assign sad = DIST_W'(dr) + DIST_W'(dg) + DIST_W'(db);

endmodule

>>> sv/nearest_palette_color_search_top.sv
`timescale 1ns / 1ps

// Channel   Ports                                            Handshake
// input     in_opcode in_entry_index in_red in_green         start & !busy
//           in_blue in_exact_only
// result    out_found out_color_index                        out_valid, one cycle
//
// On a palette write busy stays low and the next transfer may follow at once.
// A search holds busy while it makes one palette read per cycle into the shared
// distance unit, over entries 0 to SCAN_LIMIT-1 (0 to 254); it ends early at
// the first exact match. The result strobe comes in the same cycle that busy
// drops, when the next transfer may already land.
// Reset clears the sequencer and all entry valid bits at once, so every entry
// reads as black. The receiver cannot stall: out_valid is a single-cycle strobe.
module nearest_palette_color_search_top import npcs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_opcode,
  input  logic [7:0]       in_entry_index,
  input  logic [CH_W-1:0]  in_red,
  input  logic [CH_W-1:0]  in_green,
  input  logic [CH_W-1:0]  in_blue,
  input  logic             in_exact_only,
  output logic             out_valid,
  output logic             out_found,
  output logic [7:0]       out_color_index
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SCAN_LIMIT - 1);

  logic                     state_r, state_nxt;
  logic [PALETTE_DEPTH-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]         rd_addr_r, rd_addr_nxt;
  logic                     issue_r, issue_nxt;
  logic                     pend_r, pend_nxt;
  logic [IDX_W-1:0]         pend_idx_r, pend_idx_nxt;
  logic                     vld_q_r, vld_q_nxt;
  rgb_t                     qry_r, qry_nxt;
  logic                     exact_r, exact_nxt;
  logic [BEST_W-1:0]        min_sad_r, min_sad_nxt;
  logic [IDX_W-1:0]         best_idx_r, best_idx_nxt;
  logic                     have_r, have_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_found_r, out_found_nxt;
  logic [7:0]               out_idx_r, out_idx_nxt;

  logic              accept;
  logic              wr_en;
  rgb_t              wr_data;
  rgb_t              ram_q;
  rgb_t              entry;
  logic [DIST_W-1:0] sad;
  logic              hit;
  logic              better;
  logic              last;

  assign accept  = start & ~busy;
  assign busy    = (state_r == ST_SCAN);
  assign wr_en   = accept & (in_opcode == OP_WRITE);
  assign wr_data = {in_red, in_green, in_blue};

  npcs_ram #(
    .WIDTH (RGB_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (wr_en),
    .waddr (in_entry_index[IDX_W-1:0]),
    .wdata (wr_data),
    .raddr (rd_addr_r),
    .rdata (ram_q)
  );

  // Entries never written read as zero
  assign entry = vld_q_r ? ram_q : '0;

  npcs_dist u_dist (
    .entry (entry),
    .query (qry_r),
    .sad   (sad)
  );

  assign hit    = (sad == '0);
  assign better = ~exact_r & (BEST_W'(sad) < min_sad_r);
  assign last   = (pend_idx_r == LAST_IDX);

  // Sequencer and scan datapath
  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    rd_addr_nxt   = rd_addr_r;
    issue_nxt     = issue_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    vld_q_nxt     = vld_q_r;
    qry_nxt       = qry_r;
    exact_nxt     = exact_r;
    min_sad_nxt   = min_sad_r;
    best_idx_nxt  = best_idx_r;
    have_nxt      = have_r;
    out_valid_nxt = 1'b0;
    out_found_nxt = out_found_r;
    out_idx_nxt   = out_idx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (wr_en) begin
          valid_nxt[in_entry_index[IDX_W-1:0]] = 1'b1;
        end
        if (accept && in_opcode == OP_SEARCH) begin
          state_nxt     = ST_SCAN;
          rd_addr_nxt   = '0;
          issue_nxt     = 1'b1;
          qry_nxt       = wr_data;
          exact_nxt     = in_exact_only;
          min_sad_nxt   = DIST_START;
          best_idx_nxt  = '0;
          have_nxt      = 1'b0;
        end
      end
      ST_SCAN: begin
        // Issue the next palette read
        if (issue_r) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = rd_addr_r;
          vld_q_nxt    = valid_r[rd_addr_r];
          if (rd_addr_r == LAST_IDX) begin
            issue_nxt = 1'b0;
          end else begin
            rd_addr_nxt = rd_addr_r + IDX_W'(1);
          end
        end
        // Evaluate the entry that came back
        if (pend_r) begin
          if (better) begin
            min_sad_nxt   = BEST_W'(sad);
            best_idx_nxt  = pend_idx_r;
            have_nxt      = 1'b1;
          end
          if (hit || last) begin
            state_nxt     = ST_IDLE;
            issue_nxt     = 1'b0;
            pend_nxt      = 1'b0;
            out_valid_nxt = 1'b1;
            out_found_nxt = hit | better | have_r;
            if (hit || better) begin
              out_idx_nxt = 8'(pend_idx_r);
            end else begin
              out_idx_nxt = 8'(best_idx_r);
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      issue_r     <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      issue_r     <= issue_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_addr_r   <= rd_addr_nxt;
    pend_idx_r  <= pend_idx_nxt;
    vld_q_r     <= vld_q_nxt;
    qry_r       <= qry_nxt;
    exact_r     <= exact_nxt;
    min_sad_r   <= min_sad_nxt;
    best_idx_r  <= best_idx_nxt;
    have_r      <= have_nxt;
    out_found_r <= out_found_nxt;
    out_idx_r   <= out_idx_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_color_index = out_found_r ? out_idx_r : 8'd0;

endmodule
